// ===== src/dual_slope_path_loss_top_assert.svh =====
// Assertion helpers for the path loss block.
`ifndef DUAL_SLOPE_PATH_LOSS_TOP_ASSERT_SVH
`define DUAL_SLOPE_PATH_LOSS_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet during rst.
`define DSPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, quiet during rst.
`define DSPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dspl_pkg.sv =====
package dspl_pkg;

  // widths of the stream fields
  localparam int TX_W   = 16;
  localparam int DIST_W = 24;
  localparam int RX_W   = 18;
  localparam int CFG_W  = 24;

  // log2 in signed Q.16, range [-8, 16]
  localparam int LOG_W  = 22;
  localparam int DIFF_W = 23;
  localparam int EXP_W  = 12;
  localparam int PROD_W = 36;
  localparam int SUM_W  = 56;
  localparam int Q_W    = SUM_W - 32;

  localparam int LOG_TABLE_DEPTH_DEF = 64;

  // 10*log10(2) in Q.16
  localparam logic signed [18:0] TEN_LOG10_2_Q16 = 19'sd197283;

  // register indexes
  localparam logic [2:0] CFG_NEAR_START     = 3'd0;
  localparam logic [2:0] CFG_FAR_START      = 3'd1;
  localparam logic [2:0] CFG_NEAR_EXPONENT  = 3'd2;
  localparam logic [2:0] CFG_FAR_EXPONENT   = 3'd3;
  localparam logic [2:0] CFG_REFERENCE_LOSS = 3'd4;

  // register reset values
  localparam logic [23:0] NEAR_START_RST     = 24'd256;
  localparam logic [23:0] FAR_START_RST      = 24'd51200;
  localparam logic [11:0] NEAR_EXPONENT_RST  = 12'd486;
  localparam logic [11:0] FAR_EXPONENT_RST   = 12'd973;
  localparam logic [15:0] REFERENCE_LOSS_RST = 16'd12253;

  // region codes
  localparam logic [1:0] REGION_NONE = 2'd0;
  localparam logic [1:0] REGION_NEAR = 2'd1;
  localparam logic [1:0] REGION_FAR  = 2'd2;

  // One log2 table entry in Q1.16 from its start value x0 = ((D+i) << 30) / D,
  // by repeated squaring. Elaboration time only.
  function automatic logic [16:0] log_entry(input logic [63:0] x0);
    logic [63:0] x;
    logic [16:0] r;
    x = x0;
    r = '0;
    if (x0 >= 64'h8000_0000) begin
      r = 17'h10000;
    end else begin
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = {r[15:0], 1'b0};
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          r[0] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== src/dspl_log2.sv =====
// Four-stage log2 of a Q16.8 value, result signed Q.16.
module dspl_log2 #(
  parameter int LOG_TABLE_DEPTH = dspl_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic [3:0]                        en,
  input  logic [dspl_pkg::DIST_W-1:0]       v,
  output logic signed [dspl_pkg::LOG_W-1:0] log_val
);

  localparam int TI_W = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int T_W  = 16 + TI_W;

  logic [16:0] tbl [0:LOG_TABLE_DEPTH];

  for (genvar i = 0; i <= LOG_TABLE_DEPTH; i++) begin : g_tbl
    localparam logic [63:0] X0 =
      ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH);
    assign tbl[i] = dspl_pkg::log_entry(X0);
  end

  // stage 1: leading one and mantissa
  logic [23:0] vz;
  logic [4:0]  p_enc;
  logic [23:0] norm;
  logic [4:0]  p1;
  logic [15:0] f1;

  always_comb begin
    vz = (v == '0) ? 24'd1 : v;
    p_enc = '0;
    for (int b = 0; b < 24; b++) begin
      if (vz[b]) p_enc = 5'(b);
    end
    norm = vz << (5'd23 - p_enc);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= p_enc;
      f1 <= norm[22:7];
    end
  end

  // stage 2: scale mantissa to table position
  logic [T_W-1:0]  t2;
  logic [TI_W-1:0] idx2;
  logic [15:0]     w2;
  logic [4:0]      p2;

  assign t2 = {{TI_W{1'b0}}, f1} * T_W'(LOG_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      idx2 <= t2[T_W-1:16];
      w2   <= t2[15:0];
      p2   <= p1;
    end
  end

  // stage 3: table read
  logic [16:0] lo3, hi3;
  logic [15:0] w3;
  logic [4:0]  p3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lo3 <= tbl[idx2];
      hi3 <= tbl[idx2 + TI_W'(1)];
      w3  <= w2;
      p3  <= p2;
    end
  end

  // stage 4: interpolate, add exponent
  logic [16:0]       span;
  logic [32:0]       prod;
  logic [17:0]       interp;
  logic signed [5:0] expo;

  always_comb begin
    span   = hi3 - lo3;
    prod   = {16'b0, span} * {17'b0, w3};
    interp = {1'b0, lo3} + {1'b0, prod[32:16]};
    expo   = $signed({1'b0, p3}) - 6'sd8;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      log_val <= $signed({expo, 16'b0}) + $signed({4'b0, interp});
    end
  end

endmodule

// ===== src/dual_slope_path_loss_top.sv =====
// Dual-slope log-distance path loss, one link per clock while m_tready is high.
//
// Input stream (s_*): one beat per link, transmit power and distance.
// Output stream (m_*): one beat per input beat, in order, received power
// (saturated signed Q10.8 dBm) in m_tdata and the region used in m_tuser.
// Config port: cfg_wen writes cfg_wdata to register cfg_index at the clock
// edge; indexes above the last register are ignored. Write only while idle.
//
// Path: each beat passes through the stage registers in order; m_tvalid rises
// when it reaches the output register. Throughput: one beat per cycle while
// m_tready is high, set by a 9-stage pipeline with a valid bit per stage: three
// log2 units (distance, near_start, far_start) over stages 1-4, slope products
// over 5-6, sum and rounding over 7-8, saturation into the output register.
// Stall: each stage loads when it is empty or the stage after it moves, so
// bubbles close up while m_tready is low and s_tready drops only once every
// stage holds a beat. Nothing is lost or repeated.
// Reset (rst, synchronous): pipeline emptied, registers back to defaults.
module dual_slope_path_loss_top #(
  parameter int LOG_TABLE_DEPTH = dspl_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] tx_power, [39:16] link_distance
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [17:0] rx_power, [23:18] zero
  output logic [1:0]  m_tuser,   // [1:0] region
  // config
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int STAGES = 9;

  typedef struct packed {
    logic signed [dspl_pkg::TX_W-1:0] tx;
    logic [1:0]                       region;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [23:0] near_start;
  logic [23:0] far_start;
  logic [11:0] near_exponent;
  logic [11:0] far_exponent;
  logic [15:0] reference_loss;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_start     <= dspl_pkg::NEAR_START_RST;
      far_start      <= dspl_pkg::FAR_START_RST;
      near_exponent  <= dspl_pkg::NEAR_EXPONENT_RST;
      far_exponent   <= dspl_pkg::FAR_EXPONENT_RST;
      reference_loss <= dspl_pkg::REFERENCE_LOSS_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dspl_pkg::CFG_NEAR_START:     near_start     <= cfg_wdata;
        dspl_pkg::CFG_FAR_START:      far_start      <= cfg_wdata;
        dspl_pkg::CFG_NEAR_EXPONENT:  near_exponent  <= cfg_wdata[11:0];
        dspl_pkg::CFG_FAR_EXPONENT:   far_exponent   <= cfg_wdata[11:0];
        dspl_pkg::CFG_REFERENCE_LOSS: reference_loss <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // en[k]: stage k+1 loads this cycle
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------- stage 1: region, side band ----------------
  logic [23:0] dist_in;
  logic [1:0]  region_in;
  side_t       side [0:7];

  assign dist_in = s_tdata[39:16];

  always_comb begin
    if (dist_in < near_start) begin
      region_in = dspl_pkg::REGION_NONE;
    end else if (dist_in < far_start) begin
      region_in = dspl_pkg::REGION_NEAR;
    end else begin
      region_in = dspl_pkg::REGION_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0].tx     <= $signed(s_tdata[15:0]);
      side[0].region <= region_in;
    end
    for (int k = 1; k < 8; k++) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // ---------------- stages 1-4: three log2 units ----------------
  logic signed [dspl_pkg::LOG_W-1:0] ld4, l0_4, l1_4;

  dspl_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_d (
    .clk(clk), .en(en[3:0]), .v(dist_in), .log_val(ld4)
  );

  dspl_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_near (
    .clk(clk), .en(en[3:0]), .v(near_start), .log_val(l0_4)
  );

  dspl_log2 #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log_far (
    .clk(clk), .en(en[3:0]), .v(far_start), .log_val(l1_4)
  );

  // ---------------- stage 5: log differences times exponent ----------------
  // region 1: near_exp * (ld - l0)
  // region 2: near_exp * (l1 - l0) + far_exp * (ld - l1)
  logic signed [dspl_pkg::DIFF_W-1:0] diff_a, diff_b;
  logic signed [dspl_pkg::PROD_W-1:0] ea5, eb5;

  always_comb begin
    if (side[3].region == dspl_pkg::REGION_FAR) begin
      diff_a = l1_4 - l0_4;
    end else begin
      diff_a = ld4 - l0_4;
    end
    diff_b = ld4 - l1_4;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ea5 <= $signed({1'b0, near_exponent}) * diff_a;
      if (side[3].region == dspl_pkg::REGION_FAR) begin
        eb5 <= $signed({1'b0, far_exponent}) * diff_b;
      end else begin
        eb5 <= '0;
      end
    end
  end

  // ---------------- stage 6: times 10*log10(2), Q.40 ----------------
  logic signed [dspl_pkg::SUM_W-1:0] sa6, sb6;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sa6 <= ea5 * dspl_pkg::TEN_LOG10_2_Q16;
      sb6 <= eb5 * dspl_pkg::TEN_LOG10_2_Q16;
    end
  end

  // ---------------- stage 7: sum ----------------
  logic signed [dspl_pkg::SUM_W-1:0] sum7;

  always_ff @(posedge clk) begin
    if (en[6]) sum7 <= sa6 + sb6;
  end

  // ---------------- stage 8: round to Q.8, tx minus reference ----------------
  // ties away from zero: add half, or half minus one on the negative side
  localparam int RX_PRE_W = 18;
  logic signed [dspl_pkg::SUM_W-1:0] rnd_sum;
  logic signed [dspl_pkg::Q_W-1:0]   q8;
  logic signed [RX_PRE_W-1:0]        pre8;

  assign rnd_sum = sum7[dspl_pkg::SUM_W-1]
                 ? sum7 + $signed(dspl_pkg::SUM_W'(32'h7FFF_FFFF))
                 : sum7 + $signed(dspl_pkg::SUM_W'(32'h8000_0000));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      if (side[6].region == dspl_pkg::REGION_NONE) begin
        q8   <= '0;
        pre8 <= RX_PRE_W'(side[6].tx);
      end else begin
        q8   <= rnd_sum[dspl_pkg::SUM_W-1:32];
        pre8 <= side[6].tx - $signed({2'b0, reference_loss});
      end
    end
  end

  // ---------------- stage 9: saturate into output register ----------------
  logic signed [25:0]               rx_full;
  logic signed [dspl_pkg::RX_W-1:0] rx_sat;
  logic signed [dspl_pkg::RX_W-1:0] rx_out;
  logic [1:0]                       region_out;

  assign rx_full = pre8 - q8;

  always_comb begin
    if (rx_full > 26'sd131071) begin
      rx_sat = 18'sd131071;
    end else if (rx_full < -26'sd131072) begin
      rx_sat = -18'sd131072;
    end else begin
      rx_sat = rx_full[dspl_pkg::RX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      rx_out     <= rx_sat;
      region_out <= side[7].region;
    end
  end

  assign m_tdata = {6'b0, rx_out};
  assign m_tuser = region_out;

  // ---------------- assertions ----------------
  `include "dual_slope_path_loss_top_assert.svh"

  `DSPL_ASSERT_NOW(a_ready_when_out_empty, !m_tvalid, s_tready, "stalled with empty output")
  `DSPL_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld[0], "accepted beat not in stage 1")
  `DSPL_ASSERT_NOW(a_region_code, m_tvalid,
    m_tuser == dspl_pkg::REGION_NONE || m_tuser == dspl_pkg::REGION_NEAR ||
    m_tuser == dspl_pkg::REGION_FAR, "bad region code")

endmodule

// ===== tb/sv/path_loss_tb_pkg.sv =====
`timescale 1ns / 1ps

package path_loss_tb_pkg;
  import dspl_pkg::*;

  typedef struct packed {
    logic signed [RX_W-1:0] rx_power;
    logic [1:0]             region;
  } link_result_t;

  localparam int     TBL_D    = LOG_TABLE_DEPTH_DEF;
  localparam longint HALF_Q32 = 64'sd2147483648;
  localparam longint RX_MAX   = 64'sd131071;
  localparam longint RX_MIN   = -64'sd131072;
  localparam int     MAX_SHOWN = 40;

  // Received-power predictor plus the queue of results still owed by the block.
  class rx_power_board;
    logic [DIST_W-1:0] near_start;
    logic [DIST_W-1:0] far_start;
    logic [EXP_W-1:0]  near_exp;
    logic [EXP_W-1:0]  far_exp;
    logic [15:0]       ref_loss;
    longint            log_frac[TBL_D+1];
    link_result_t      expected_rx[$];
    int                errors;
    int                beats;
    int                links;
    int                region_seen[3];

    function new();
      near_start = NEAR_START_RST;
      far_start  = FAR_START_RST;
      near_exp   = NEAR_EXPONENT_RST;
      far_exp    = FAR_EXPONENT_RST;
      ref_loss   = REFERENCE_LOSS_RST;
      errors = 0;
      beats  = 0;
      links  = 0;
      for (int i = 0; i < 3; i++) region_seen[i] = 0;
      for (int i = 0; i <= TBL_D; i++) log_frac[i] = frac_log2(i);
    endfunction

    // log2(1 + i/D) in Q1.16, bit by bit through repeated squaring
    function longint frac_log2(int i);
      logic [63:0] x;
      longint r;
      x = i + TBL_D;
      x = (x << 30) / TBL_D;
      if (x >= 64'h8000_0000) return 64'sd65536;
      r = 0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = r * 2;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          r = r + 1;
        end
      end
      return r;
    endfunction

    // log2 of a Q16.8 distance, signed Q.16; zero counts as one LSB
    function longint dist_log2(logic [DIST_W-1:0] v);
      logic [DIST_W-1:0] vv;
      logic [DIST_W-1:0] sh;
      logic [15:0]       f;
      logic [31:0]       t;
      int                p;
      int                idx;
      longint            w;
      longint            lo;
      longint            hi;
      vv = v;
      if (vv == 0) vv = 1;
      p = 23;
      while (p > 0 && !vv[p]) p--;
      sh  = vv << (23 - p);
      f   = sh[22:7];
      t   = f * TBL_D;
      idx = t >> 16;
      w   = t & 32'hFFFF;
      lo  = log_frac[idx];
      hi  = log_frac[idx + 1];
      return longint'(p - 8) * 64'sd65536 + lo + (((hi - lo) * w) >>> 16);
    endfunction

    // exponent Q.8 * log difference Q.16 * 10log10(2) Q.16 -> Q.40
    function longint slope_db(logic [EXP_W-1:0] expo, longint diff);
      return longint'(expo) * diff * longint'(TEN_LOG10_2_Q16);
    endfunction

    function link_result_t predict_link(logic [TX_W-1:0] tx_bits, logic [DIST_W-1:0] d);
      longint       tx;
      longint       ld;
      longint       l0;
      longint       l1;
      longint       sum;
      longint       q;
      longint       loss;
      longint       rx;
      link_result_t r;
      tx   = longint'($signed(tx_bits));
      loss = 0;
      sum  = 0;
      if (d < near_start) begin
        r.region = REGION_NONE;
      end else begin
        ld = dist_log2(d);
        l0 = dist_log2(near_start);
        if (d < far_start) begin
          r.region = REGION_NEAR;
          sum = slope_db(near_exp, ld - l0);
        end else begin
          l1 = dist_log2(far_start);
          r.region = REGION_FAR;
          sum = slope_db(near_exp, l1 - l0) + slope_db(far_exp, ld - l1);
        end
        // Q.40 -> Q.8, ties away from zero
        if (sum >= 0) q = (sum + HALF_Q32) >>> 32;
        else q = -((-sum + HALF_Q32) >>> 32);
        loss = longint'(ref_loss) + q;
      end
      rx = tx - loss;
      if (rx > RX_MAX) rx = RX_MAX;
      if (rx < RX_MIN) rx = RX_MIN;
      r.rx_power = RX_W'(rx);
      return r;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_NEAR_START:     near_start = v[DIST_W-1:0];
        CFG_FAR_START:      far_start  = v[DIST_W-1:0];
        CFG_NEAR_EXPONENT:  near_exp   = v[EXP_W-1:0];
        CFG_FAR_EXPONENT:   far_exp    = v[EXP_W-1:0];
        CFG_REFERENCE_LOSS: ref_loss   = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_link(logic [TX_W-1:0] tx, logic [DIST_W-1:0] d);
      links++;
      expected_rx.push_back(predict_link(tx, d));
    endfunction

    function int pending();
      return expected_rx.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("mismatch at result beat %0d: %s", beats, msg);
    endtask

    task check_beat(logic [23:0] data, logic [1:0] user);
      link_result_t           e;
      logic signed [RX_W-1:0] got;
      beats++;
      if (expected_rx.size() == 0) begin
        report($sformatf("result beat with no link pending, tdata %h tuser %0d", data, user));
        return;
      end
      e   = expected_rx.pop_front();
      got = data[RX_W-1:0];
      if (got !== e.rx_power)
        report($sformatf("rx_power %0d, expected %0d", got, e.rx_power));
      if (data[23:RX_W] !== '0)
        report($sformatf("tdata pad bits %h, expected zero", data[23:RX_W]));
      if (user !== e.region)
        report($sformatf("region %0d, expected %0d", user, e.region));
      if (e.region < 3) region_seen[e.region]++;
    endtask
  endclass

endpackage

// ===== tb/sv/dual_slope_path_loss_top_tb.sv =====
`timescale 1ns / 1ps

module dual_slope_path_loss_top_tb;
  import dspl_pkg::*;
  import path_loss_tb_pkg::*;

  // watchdog: cycles without any beat on either stream; slowest legal case is
  // the longest source gap or sink stall plus the pipe and a config load
  localparam int IDLE_LIMIT      = 2000;
  localparam int PIPE_LATENCY    = 9;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 80;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [39:0] s_tdata   = '0;   // [15:0] tx_power, [39:16] link_distance
  logic        m_tready  = 1'b0;
  logic        cfg_wen   = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;          // [17:0] rx_power, [23:18] zero
  logic [1:0]  m_tuser;          // [1:0] region

  rx_power_board board = new();

  int idle_cycles   = 0;
  int settings_used = 1;         // reset defaults count as the first setting
  bit gaps_off      = 1'b0;      // source sends back to back while set

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dual_slope_path_loss_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // log-uniform distance so every octave of Q16.8 shows up
  function automatic logic [23:0] rand_dist();
    int          sh;
    logic [31:0] mask;
    sh   = $urandom_range(0, 23);
    mask = (32'h1 << (sh + 1)) - 1;
    return 24'($urandom & mask);
  endfunction

  // distance within a few LSBs of a breakpoint, clamped to the field
  function automatic logic [23:0] near_by(logic [23:0] base);
    int     off;
    longint x;
    off = $urandom_range(0, 16);
    x   = longint'(base) + longint'(off) - 64'sd8;
    if (x < 0) x = 0;
    if (x > 64'sd16777215) x = 64'sd16777215;
    return 24'(x);
  endfunction

  // one link beat; accepted at the edge where s_tvalid and s_tready are both high
  task automatic send_link(logic [15:0] tx, logic [23:0] d);
    int gap;
    gap = gaps_off ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_link(tx, d);
  endtask

  // source idle until the block has returned everything it owes
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // keeps cfg_wen high across back-to-back writes; load_settings drops it
  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  task automatic load_settings(logic [23:0] ns, logic [23:0] fs, logic [11:0] ne,
                               logic [11:0] fe, logic [15:0] rl);
    write_reg(CFG_NEAR_START, ns);
    write_reg(CFG_FAR_START, fs);
    write_reg(CFG_NEAR_EXPONENT, {12'd0, ne});
    write_reg(CFG_FAR_EXPONENT, {12'd0, fe});
    write_reg(CFG_REFERENCE_LOSS, {8'd0, rl});
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  // mostly ordered breakpoints, sometimes crossed; exponents either realistic
  // (1..5) or anywhere in Q4.8
  task automatic random_settings();
    logic [23:0] ns;
    logic [23:0] fs;
    logic [24:0] span;
    logic [11:0] ne;
    logic [11:0] fe;
    ns = rand_dist();
    if ($urandom_range(0, 9) < 8) begin
      span = ns + rand_dist();
      fs   = span[24] ? 24'hFF_FFFF : span[23:0];
    end else begin
      fs = rand_dist();
    end
    ne = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(256, 1280));
    fe = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(256, 1280));
    load_settings(ns, fs, ne, fe, 16'($urandom));
  endtask

  // random link; distances cluster at the breakpoints to hit the region edges
  task automatic random_link();
    logic [15:0] tx;
    logic [23:0] d;
    int          pick;
    tx   = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) d = near_by(board.near_start);
    else if (pick < 45) d = near_by(board.far_start);
    else if (pick < 85) d = rand_dist();
    else d = 24'($urandom);
    send_link(tx, d);
  endtask

  // sink: stretches of steady ready, stretches of random stalls
  initial begin : sink_pacing
    int seg;
    int stall;
    bit steady;
    forever begin
      steady = ($urandom_range(0, 2) == 0);
      seg    = $urandom_range(20, 200);
      if (steady) begin
        m_tready <= 1'b1;
        repeat (seg) @(posedge clk);
      end else begin
        repeat (seg) begin
          stall = pick_gap();
          if (stall > 0) begin
            m_tready <= 1'b0;
            repeat (stall) @(posedge clk);
          end
          m_tready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // every output beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, board.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 1 m and 200 m breakpoints
    send_link(16'h7FFF, 24'd0);          // max power, zero distance, no loss
    send_link(16'h8000, 24'hFF_FFFF);    // min power, max distance
    send_link(16'h0000, 24'd255);        // one LSB short of near_start
    send_link(16'h0000, 24'd256);        // exactly at near_start
    send_link(16'h1400, 24'd51199);      // last point of the first slope
    send_link(16'h1400, 24'd51200);      // exactly at far_start
    send_link(16'hFF00, 24'h12_3456);
    send_link(16'h5555, 24'hAA_AAAA);
    send_link(16'hAAAA, 24'h55_5555);

    // every register at its top value
    wait_idle();
    load_settings(24'hFF_FFFF, 24'hFF_FFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_link(16'h0000, 24'hFF_FFFE);
    send_link(16'h8000, 24'hFF_FFFF);
    send_link(16'h7FFF, 24'hFF_FFFF);

    // every register zero: both breakpoints hit the zero-log case
    wait_idle();
    load_settings(24'd0, 24'd0, 12'd0, 12'd0, 16'd0);
    send_link(16'h1234, 24'd0);
    send_link(16'hEDCB, 24'hFF_FFFF);

    // crossed breakpoints: negative first slope drives rx_power into the top rail
    wait_idle();
    load_settings(24'hFF_FFFF, 24'd0, 12'hFFF, 12'd0, 16'd0);
    send_link(16'h7FFF, 24'hFF_FFFF);
    send_link(16'h1234, 24'h80_0000);

    // steep slopes from a zero near_start: bottom rail, zero-log distance
    wait_idle();
    load_settings(24'd0, 24'd1, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_link(16'h8000, 24'hFF_FFFF);
    send_link(16'h0000, 24'd0);
    send_link(16'h0000, 24'd1);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      random_settings();
      gaps_off = (ph == 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the source mid-phase until the pipe has fully drained
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) wait_idle();
        random_link();
      end
    end
    gaps_off = 1'b0;

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("run covered %0d links under %0d register settings, %0d result beats checked",
             board.links, settings_used, board.beats);
    $display("regions hit: below near_start %0d, first slope %0d, second slope %0d",
             board.region_seen[0], board.region_seen[1], board.region_seen[2]);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
